>>> design/twhf_pkg.sv
package twhf_pkg;

   localparam int MAX_TILE_W   = 256;
   localparam int MAX_TILE_H   = 16;
   localparam int MAX_HALO     = 4;
   localparam int BUFFER_COUNT = 2;

   // Operand and product widths of the shared multiplier.
   localparam int MUL_A_W = 25;
   localparam int MUL_B_W = 20;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // Divider geometry: 32-bit dividend, 16-bit divisor, one quotient bit a cycle.
   localparam int DIV_N_W = 32;
   localparam int DIV_D_W = 16;
   localparam int DIV_C_W = $clog2(DIV_N_W);

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 20;

   localparam logic [1:0] CMD_BEGIN    = 2'd0;
   localparam logic [1:0] CMD_NEXT     = 2'd1;
   localparam logic [1:0] CMD_END      = 2'd2;
   localparam logic [1:0] CMD_PREFETCH = 2'd3;

   localparam logic [1:0] KIND_PREFETCH  = 2'd0;
   localparam logic [1:0] KIND_WRITEBACK = 2'd1;
   localparam logic [1:0] KIND_STATUS    = 2'd2;
   localparam logic [1:0] KIND_REFUSED   = 2'd3;

   localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd0;
   localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd1;
   localparam logic [2:0] REG_TILE_WIDTH    = 3'd2;
   localparam logic [2:0] REG_TILE_HEIGHT   = 3'd3;
   localparam logic [2:0] REG_ROW_PITCH     = 3'd4;
   localparam logic [2:0] REG_ELEMENT_BYTES = 3'd5;
   localparam logic [2:0] REG_HALO_COLUMNS  = 3'd6;
   localparam logic [2:0] REG_HALO_ROWS     = 3'd7;

   localparam logic [11:0] MAX_BYTE_COUNT = 12'd2112;

endpackage

>>> design/twhf_req_if.sv
interface twhf_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic        tile_was_modified;
   logic [31:0] requested_tile;

   modport source (output valid, cmd, tile_was_modified, requested_tile, input ready);
   modport sink   (input valid, cmd, tile_was_modified, requested_tile, output ready);
endinterface

>>> design/twhf_rsp_if.sv
interface twhf_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic        buffer_select;
   logic [35:0] memory_offset;
   logic [15:0] buffer_offset;
   logic [11:0] byte_count;
   logic [31:0] tile_number;
   logic [15:0] start_col;
   logic [15:0] start_row;
   logic [8:0]  cur_width;
   logic [4:0]  cur_height;
   logic        is_last_tile;
   logic        last_of_run;

   modport source (output valid, kind, buffer_select, memory_offset, buffer_offset,
                   byte_count, tile_number, start_col, start_row, cur_width,
                   cur_height, is_last_tile, last_of_run, input ready);
   modport sink   (input valid, kind, buffer_select, memory_offset, buffer_offset,
                   byte_count, tile_number, start_col, start_row, cur_width,
                   cur_height, is_last_tile, last_of_run, output ready);
endinterface

>>> design/twhf_div.sv
// Restoring divider, one quotient bit per cycle.
module twhf_div
   import twhf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DIV_N_W-1:0] dividend,
   input  logic [DIV_D_W-1:0] divisor,
   output logic               done,
   output logic [DIV_N_W-1:0] quotient,
   output logic [DIV_D_W-1:0] remainder
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [DIV_C_W-1:0] cnt_ff, cnt_in;
   logic [DIV_N_W-1:0] quot_ff, quot_in;
   logic [DIV_D_W-1:0] rem_ff, rem_in;
   logic [DIV_D_W-1:0] dvs_ff, dvs_in;
   logic [DIV_D_W:0]   rem_shift;
   logic               fits;

   always_comb begin
      rem_shift = {rem_ff, quot_ff[DIV_N_W-1]};
      fits      = rem_shift >= {1'b0, dvs_ff};
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      quot_in   = quot_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quot_in = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quot_in = {quot_ff[DIV_N_W-2:0], fits};
         rem_in  = fits ? DIV_D_W'(rem_shift - {1'b0, dvs_ff}) : rem_shift[DIV_D_W-1:0];
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == DIV_C_W'(DIV_N_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;

endmodule

>>> design/twhf_mul.sv
// Shared multiplier with a registered product.
module twhf_mul
   import twhf_pkg::*;
(
   input  logic               clock,
   input  logic [MUL_A_W-1:0] op_a,
   input  logic [MUL_B_W-1:0] op_b,
   output logic [MUL_P_W-1:0] product
);

   logic [MUL_P_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= MUL_P_W'(op_a) * MUL_P_W'(op_b);
   end

   assign product = prod_ff;

endmodule

>>> design/tile_walker_halo_fetch_top.sv
// Channel  | Dir | Payload
// req_chan | in  | cmd, tile_was_modified, requested_tile
// rsp_chan | out | kind, buffer_select, memory_offset ... is_last_tile, last_of_run
// csr_*    | in  | csr_write_enable, csr_index, csr_write_data (write only)
//
// One command is taken at a time; req_chan.ready is high only while the sequencer idles.
// After the accepting edge a command passes through setup, a serial divide where needed, a row
// pass setup of tile geometry and shared multiplies for each run of rows, and the status word.
// A begin runs up to two prefetches, a next runs a prefetch when a tile follows and writes back
// first when dirty, and a refusal produces only the status word.
// Reset is synchronous and returns the registers to their reset values and the walker to
// its first tile with nothing to advance. A stall on rsp_chan holds the current word.
module tile_walker_halo_fetch_top
   import twhf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   twhf_req_if.sink               req_chan,
   twhf_rsp_if.source             rsp_chan,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   typedef enum logic [4:0] {
      ST_IDLE, ST_PITCH, ST_PITCH_W, ST_B_DIV_X, ST_B_DIV_Y, ST_B_MUL, ST_B_SET,
      ST_B_SECOND, ST_B_FIN, ST_NEXT_ADV, ST_NEXT_PF, ST_NEXT_FIN, ST_STATUS_GO,
      ST_PF_START, ST_PF_DIV, ST_G_SX, ST_G_SY, ST_G_WIN, ST_G_CALC, ST_S_RB,
      ST_S_MY, ST_S_MX, ST_S_MT, ST_S_ML, ST_S_ME, ST_S_MC, ST_S_R0, ST_ROWS, ST_STAT
   } state_type;

   typedef enum logic [1:0] {MODE_PF, MODE_WB, MODE_ST} mode_type;

   // Configuration registers.
   logic [15:0] img_w_ff, img_h_ff;
   logic [8:0]  tile_w_ff;
   logic [4:0]  tile_h_ff;
   logic [19:0] pitch_reg_ff;
   logic [3:0]  elem_ff;
   logic [2:0]  halo_x_ff, halo_y_ff;

   // Walker state.
   logic [15:0] col_tile_ff, row_tile_ff, tiles_across_ff;
   logic [31:0] tile_counter_ff, tiles_total_ff;
   logic        active_buf_ff, final_flag_ff;

   // Sequencer.
   state_type   state_ff, ret_ff;
   mode_type    mode_ff;
   logic [1:0]  cmd_ff, st_kind_ff;
   logic        dirty_ff;
   logic [31:0] req_tile_ff, pf_idx_ff;
   logic        pf_buf_ff;
   logic [19:0] pitch_ff;
   logic [15:0] across_tmp_ff, gcol_ff, grow_ff;
   logic [24:0] sx_ff, fx0_ff;
   logic [20:0] sy_ff, fy0_ff;
   logic [8:0]  fw_ff, cw_ff;
   logic [4:0]  fh_ff, ch_ff, limit_ff, cnt_ff;
   logic [2:0]  top_ff, left_ff;
   logic [11:0] rb_ff, bytes_ff;
   logic [35:0] base_ff, mem_ff;
   logic [15:0] boff_ff;
   logic [10:0] tmp_ff;

   // Effective register values after clamping.
   logic [15:0] e_w, e_h;
   logic [8:0]  e_tw;
   logic [4:0]  e_th;
   logic [3:0]  e_eb;
   logic [2:0]  e_hx, e_hy;
   logic [15:0] across_eff;

   logic               mul_sel_pf;
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [MUL_P_W-1:0] prod;

   logic               div_start, div_done;
   logic [DIV_N_W-1:0] div_n, div_q;
   logic [DIV_D_W-1:0] div_d, div_r;

   // Window arithmetic on the registered tile origin.
   logic [25:0] x1, ex;
   logic [21:0] y1, ey;
   logic [15:0] x1c, exc, y1c, eyc;
   logic [24:0] fx0_c;
   logic [20:0] fy0_c;
   logic [32:0] next_idx;
   logic        next_has;
   logic [15:0] col_inc;
   logic        rsp_fire;

   always_comb begin
      e_w  = (img_w_ff == 16'd0) ? 16'd1 : img_w_ff;
      e_h  = (img_h_ff == 16'd0) ? 16'd1 : img_h_ff;
      e_tw = (tile_w_ff == 9'd0) ? 9'd1 :
             ((tile_w_ff > 9'(MAX_TILE_W)) ? 9'(MAX_TILE_W) : tile_w_ff);
      e_th = (tile_h_ff == 5'd0) ? 5'd1 :
             ((tile_h_ff > 5'(MAX_TILE_H)) ? 5'(MAX_TILE_H) : tile_h_ff);
      e_eb = (elem_ff == 4'd0) ? 4'd1 : ((elem_ff > 4'd8) ? 4'd8 : elem_ff);
      e_hx = (halo_x_ff > 3'(MAX_HALO)) ? 3'(MAX_HALO) : halo_x_ff;
      e_hy = (halo_y_ff > 3'(MAX_HALO)) ? 3'(MAX_HALO) : halo_y_ff;
      across_eff = (tiles_across_ff == 16'd0) ? 16'd1 : tiles_across_ff;
   end

   always_comb begin
      x1    = 26'(sx_ff) + 26'(e_tw) + 26'(e_hx);
      x1c   = (x1 > 26'(e_w)) ? e_w : x1[15:0];
      ex    = 26'(sx_ff) + 26'(e_tw);
      exc   = (ex > 26'(e_w)) ? e_w : ex[15:0];
      fx0_c = (sx_ff > 25'(e_hx)) ? (sx_ff - 25'(e_hx)) : 25'd0;
      y1    = 22'(sy_ff) + 22'(e_th) + 22'(e_hy);
      y1c   = (y1 > 22'(e_h)) ? e_h : y1[15:0];
      ey    = 22'(sy_ff) + 22'(e_th);
      eyc   = (ey > 22'(e_h)) ? e_h : ey[15:0];
      fy0_c = (sy_ff > 21'(e_hy)) ? (sy_ff - 21'(e_hy)) : 21'd0;
   end

   assign next_idx = {1'b0, tile_counter_ff} + 33'd1;
   assign next_has = next_idx < {1'b0, tiles_total_ff};
   assign col_inc  = col_tile_ff + 16'd1;

   // Operand selection for the shared multiplier.
   assign mul_sel_pf = (mode_ff == MODE_PF);
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_PITCH: begin mul_a = MUL_A_W'(e_w);          mul_b = MUL_B_W'(e_eb);      end
         ST_B_MUL: begin mul_a = MUL_A_W'(across_tmp_ff); mul_b = MUL_B_W'(div_q[15:0]); end
         ST_G_SX:  begin mul_a = MUL_A_W'(gcol_ff);      mul_b = MUL_B_W'(e_tw);      end
         ST_G_SY:  begin mul_a = MUL_A_W'(grow_ff);      mul_b = MUL_B_W'(e_th);      end
         ST_S_RB:  begin mul_a = MUL_A_W'(fw_ff);        mul_b = MUL_B_W'(e_eb);      end
         ST_S_MY:  begin
            mul_a = mul_sel_pf ? MUL_A_W'(fy0_ff) : MUL_A_W'(sy_ff);
            mul_b = pitch_ff;
         end
         ST_S_MX:  begin
            mul_a = mul_sel_pf ? fx0_ff : sx_ff;
            mul_b = MUL_B_W'(e_eb);
         end
         ST_S_MT:  begin mul_a = MUL_A_W'(top_ff);       mul_b = MUL_B_W'(fw_ff);     end
         ST_S_ME:  begin mul_a = MUL_A_W'(tmp_ff);       mul_b = MUL_B_W'(e_eb);      end
         ST_S_MC:  begin mul_a = MUL_A_W'(cw_ff);        mul_b = MUL_B_W'(e_eb);      end
         default:  begin mul_a = '0;                     mul_b = '0;                  end
      endcase
   end

   twhf_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (prod)
   );

   // The divider serves the tile counts at begin and the tile position of a prefetch.
   always_comb begin
      div_start = 1'b0;
      div_n     = '0;
      div_d     = '0;
      case (state_ff)
         ST_PITCH_W: begin
            div_start = (cmd_ff == CMD_BEGIN);
            div_n     = DIV_N_W'(17'(e_w) + 17'(e_tw) - 17'd1);
            div_d     = DIV_D_W'(e_tw);
         end
         ST_B_DIV_X: begin
            div_start = div_done;
            div_n     = DIV_N_W'(17'(e_h) + 17'(e_th) - 17'd1);
            div_d     = DIV_D_W'(e_th);
         end
         ST_PF_START: begin
            div_start = 1'b1;
            div_n     = pf_idx_ff;
            div_d     = across_eff;
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   twhf_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_n),
      .divisor   (div_d),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         img_w_ff     <= 16'd1;
         img_h_ff     <= 16'd1;
         tile_w_ff    <= 9'd1;
         tile_h_ff    <= 5'd1;
         pitch_reg_ff <= 20'd1;
         elem_ff      <= 4'd1;
         halo_x_ff    <= 3'd0;
         halo_y_ff    <= 3'd0;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_IMAGE_WIDTH:   img_w_ff     <= csr_write_data[15:0];
            REG_IMAGE_HEIGHT:  img_h_ff     <= csr_write_data[15:0];
            REG_TILE_WIDTH:    tile_w_ff    <= csr_write_data[8:0];
            REG_TILE_HEIGHT:   tile_h_ff    <= csr_write_data[4:0];
            REG_ROW_PITCH:     pitch_reg_ff <= csr_write_data;
            REG_ELEMENT_BYTES: elem_ff      <= csr_write_data[3:0];
            REG_HALO_COLUMNS:  halo_x_ff    <= csr_write_data[2:0];
            REG_HALO_ROWS:     halo_y_ff    <= csr_write_data[2:0];
            default:           img_w_ff     <= img_w_ff;
         endcase
      end
   end

   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;

   // Sequencer. Each multiply state presents operands; the next state takes the product.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         ret_ff          <= ST_IDLE;
         mode_ff         <= MODE_ST;
         col_tile_ff     <= '0;
         row_tile_ff     <= '0;
         tile_counter_ff <= '0;
         active_buf_ff   <= 1'b0;
         final_flag_ff   <= 1'b1;
         tiles_across_ff <= '0;
         tiles_total_ff  <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_chan.valid) begin
                  cmd_ff      <= req_chan.cmd;
                  dirty_ff    <= req_chan.tile_was_modified;
                  req_tile_ff <= req_chan.requested_tile;
                  state_ff    <= ST_PITCH;
               end
            end
            ST_PITCH: state_ff <= ST_PITCH_W;
            ST_PITCH_W: begin
               pitch_ff   <= (pitch_reg_ff != 20'd0) ? pitch_reg_ff : prod[19:0];
               st_kind_ff <= KIND_STATUS;
               gcol_ff    <= col_tile_ff;
               grow_ff    <= row_tile_ff;
               case (cmd_ff)
                  CMD_BEGIN: state_ff <= ST_B_DIV_X;
                  CMD_NEXT: begin
                     if (final_flag_ff) begin
                        st_kind_ff <= KIND_REFUSED;
                        state_ff   <= ST_STATUS_GO;
                     end else if (dirty_ff) begin
                        mode_ff  <= MODE_WB;
                        ret_ff   <= ST_NEXT_ADV;
                        state_ff <= ST_G_SX;
                     end else begin
                        state_ff <= ST_NEXT_ADV;
                     end
                  end
                  CMD_END: begin
                     if (dirty_ff) begin
                        mode_ff  <= MODE_WB;
                        ret_ff   <= ST_STATUS_GO;
                        state_ff <= ST_G_SX;
                     end else begin
                        state_ff <= ST_STATUS_GO;
                     end
                  end
                  default: begin
                     if (req_tile_ff >= tiles_total_ff) begin
                        st_kind_ff <= KIND_REFUSED;
                        state_ff   <= ST_STATUS_GO;
                     end else begin
                        pf_idx_ff <= req_tile_ff;
                        pf_buf_ff <= ~active_buf_ff;
                        ret_ff    <= ST_STATUS_GO;
                        state_ff  <= ST_PF_START;
                     end
                  end
               endcase
            end
            ST_B_DIV_X: begin
               if (div_done) begin
                  across_tmp_ff <= div_q[15:0];
                  state_ff      <= ST_B_DIV_Y;
               end
            end
            ST_B_DIV_Y: if (div_done) state_ff <= ST_B_MUL;
            ST_B_MUL: state_ff <= ST_B_SET;
            ST_B_SET: begin
               tiles_across_ff <= across_tmp_ff;
               tiles_total_ff  <= prod[31:0];
               col_tile_ff     <= '0;
               row_tile_ff     <= '0;
               tile_counter_ff <= '0;
               active_buf_ff   <= 1'b0;
               pf_idx_ff       <= 32'd0;
               pf_buf_ff       <= 1'b0;
               ret_ff          <= ST_B_SECOND;
               state_ff        <= ST_PF_START;
            end
            ST_B_SECOND: begin
               if (tiles_total_ff > 32'd1) begin
                  pf_idx_ff <= 32'd1;
                  pf_buf_ff <= 1'b1;
                  ret_ff    <= ST_B_FIN;
                  state_ff  <= ST_PF_START;
               end else begin
                  state_ff <= ST_B_FIN;
               end
            end
            ST_B_FIN: begin
               final_flag_ff <= (tiles_total_ff <= 32'd1);
               state_ff      <= ST_STATUS_GO;
            end
            ST_NEXT_ADV: begin
               tile_counter_ff <= tile_counter_ff + 32'd1;
               if (col_inc >= tiles_across_ff) begin
                  col_tile_ff <= '0;
                  row_tile_ff <= row_tile_ff + 16'd1;
               end else begin
                  col_tile_ff <= col_inc;
               end
               active_buf_ff <= ~active_buf_ff;
               state_ff      <= ST_NEXT_PF;
            end
            ST_NEXT_PF: begin
               if (next_has) begin
                  pf_idx_ff <= next_idx[31:0];
                  pf_buf_ff <= ~active_buf_ff;
                  ret_ff    <= ST_NEXT_FIN;
                  state_ff  <= ST_PF_START;
               end else begin
                  state_ff <= ST_NEXT_FIN;
               end
            end
            ST_NEXT_FIN: begin
               final_flag_ff <= ~next_has;
               state_ff      <= ST_STATUS_GO;
            end
            ST_STATUS_GO: begin
               mode_ff  <= MODE_ST;
               gcol_ff  <= col_tile_ff;
               grow_ff  <= row_tile_ff;
               state_ff <= ST_G_SX;
            end
            ST_PF_START: begin
               mode_ff  <= MODE_PF;
               state_ff <= ST_PF_DIV;
            end
            ST_PF_DIV: begin
               if (div_done) begin
                  gcol_ff  <= div_r;
                  grow_ff  <= div_q[15:0];
                  state_ff <= ST_G_SX;
               end
            end
            ST_G_SX: state_ff <= ST_G_SY;
            ST_G_SY: begin
               sx_ff    <= prod[24:0];
               state_ff <= ST_G_WIN;
            end
            ST_G_WIN: begin
               sy_ff    <= prod[20:0];
               state_ff <= ST_G_CALC;
            end
            ST_G_CALC: begin
               fx0_ff  <= fx0_c;
               fy0_ff  <= fy0_c;
               fw_ff   <= (25'(x1c) > fx0_c) ? 9'(25'(x1c) - fx0_c) : 9'd0;
               fh_ff   <= (21'(y1c) > fy0_c) ? 5'(21'(y1c) - fy0_c) : 5'd0;
               cw_ff   <= (25'(exc) > sx_ff) ? 9'(25'(exc) - sx_ff) : 9'd0;
               ch_ff   <= (21'(eyc) > sy_ff) ? 5'(21'(eyc) - sy_ff) : 5'd0;
               top_ff  <= 3'(sy_ff - fy0_c);
               left_ff <= 3'(sx_ff - fx0_c);
               state_ff <= (mode_ff == MODE_ST) ? ST_STAT : ST_S_RB;
            end
            ST_S_RB: state_ff <= ST_S_MY;
            ST_S_MY: begin
               rb_ff    <= prod[11:0];
               state_ff <= ST_S_MX;
            end
            ST_S_MX: begin
               base_ff  <= prod[35:0];
               state_ff <= ST_S_MT;
            end
            ST_S_MT: begin
               mem_ff   <= base_ff + prod[35:0];
               state_ff <= ST_S_ML;
            end
            ST_S_ML: begin
               tmp_ff   <= prod[10:0] + 11'(left_ff);
               state_ff <= ST_S_ME;
            end
            ST_S_ME: state_ff <= ST_S_MC;
            ST_S_MC: begin
               boff_ff  <= mul_sel_pf ? 16'd0 : prod[15:0];
               state_ff <= ST_S_R0;
            end
            ST_S_R0: begin
               bytes_ff <= mul_sel_pf ? rb_ff : prod[11:0];
               limit_ff <= mul_sel_pf ? fh_ff : ch_ff;
               cnt_ff   <= '0;
               if ((mul_sel_pf ? fh_ff : ch_ff) == 5'd0) begin
                  state_ff <= ret_ff;
               end else begin
                  state_ff <= ST_ROWS;
               end
            end
            ST_ROWS: begin
               if (rsp_fire) begin
                  mem_ff  <= mem_ff + 36'(pitch_ff);
                  boff_ff <= boff_ff + 16'(rb_ff);
                  cnt_ff  <= cnt_ff + 5'd1;
                  if (cnt_ff + 5'd1 == limit_ff) begin
                     state_ff <= ret_ff;
                  end
               end
            end
            ST_STAT: if (rsp_fire) state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_chan.ready = (state_ff == ST_IDLE);

   // Result word, selected from registers only.
   always_comb begin
      rsp_chan.valid         = (state_ff == ST_ROWS) || (state_ff == ST_STAT);
      rsp_chan.kind          = st_kind_ff;
      rsp_chan.buffer_select = active_buf_ff;
      rsp_chan.memory_offset = '0;
      rsp_chan.buffer_offset = '0;
      rsp_chan.byte_count    = '0;
      rsp_chan.tile_number   = tile_counter_ff;
      rsp_chan.start_col     = sx_ff[15:0];
      rsp_chan.start_row     = sy_ff[15:0];
      rsp_chan.cur_width     = cw_ff;
      rsp_chan.cur_height    = ch_ff;
      rsp_chan.is_last_tile  = final_flag_ff;
      rsp_chan.last_of_run   = 1'b1;
      if (state_ff == ST_ROWS) begin
         rsp_chan.kind          = mul_sel_pf ? KIND_PREFETCH : KIND_WRITEBACK;
         rsp_chan.buffer_select = mul_sel_pf ? pf_buf_ff : active_buf_ff;
         rsp_chan.memory_offset = mem_ff;
         rsp_chan.buffer_offset = boff_ff;
         rsp_chan.byte_count    = bytes_ff;
         rsp_chan.tile_number   = '0;
         rsp_chan.start_col     = '0;
         rsp_chan.start_row     = '0;
         rsp_chan.cur_width     = '0;
         rsp_chan.cur_height    = '0;
         rsp_chan.is_last_tile  = 1'b0;
         rsp_chan.last_of_run   = 1'b0;
      end
   end

endmodule

>>> design/twhf_checker.sv
module twhf_checker
   import twhf_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic [35:0] rsp_memory_offset,
   input logic [11:0] rsp_byte_count,
   input logic        rsp_last_of_run
);

   // A word is never offered while a new command could be taken.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && req_ready))
      else $error("result offered while idle");

   // After a command is taken the block stays busy for at least the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready right after accept");

   // A refused command produces only the closing word.
   a_refused_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_REFUSED) |-> rsp_last_of_run)
      else $error("refused word not last");

   // A stalled word holds.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_kind) && $stable(rsp_memory_offset)
          && $stable(rsp_byte_count)))
      else $error("stalled word changed");

endmodule

bind tile_walker_halo_fetch_top twhf_checker u_twhf_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_kind          (rsp_chan.kind),
   .rsp_memory_offset (rsp_chan.memory_offset),
   .rsp_byte_count    (rsp_chan.byte_count),
   .rsp_last_of_run   (rsp_chan.last_of_run)
);

>>> tb/testbench.sv
module testbench
   import twhf_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   // One descriptor or status word as the walker reports it.
   typedef struct {
      logic [1:0]  kind;
      logic        bsel;
      logic [35:0] mem_off;
      logic [15:0] buf_off;
      logic [11:0] nbytes;
      logic [31:0] tile;
      logic [15:0] scol;
      logic [15:0] srow;
      logic [8:0]  cw;
      logic [4:0]  ch;
      logic        fin_tile;
      logic        last_run;
   } tile_word_type;

   // A row of the directed table: either a register write or a command.
   typedef struct {
      bit            is_csr;
      logic [2:0]    idx;
      logic [19:0]   data;
      logic [1:0]    cmd;
      logic          dirty;
      logic [31:0]   req_tile;
      bit            has_exp;
      tile_word_type exp_word;
   } script_row_type;

   logic clock;
   logic reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   twhf_req_if req_chan ();
   twhf_rsp_if rsp_chan ();

   tile_walker_halo_fetch_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // The clock runs with a 10 ns period.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Shadow copies of the configuration registers, held at their register widths.
   logic [15:0] cfg_img_w, cfg_img_h;
   logic [8:0]  cfg_tile_w;
   logic [4:0]  cfg_tile_h;
   logic [19:0] cfg_pitch;
   logic [3:0]  cfg_elem;
   logic [2:0]  cfg_halo_x, cfg_halo_y;

   // Shadow copy of the walker state.
   logic [15:0] walk_col, walk_row;
   logic [31:0] walk_count;
   logic        walk_buf;
   logic        walk_final;
   logic [31:0] walk_across;
   logic [31:0] walk_total;

   tile_word_type  expected_words[$];
   script_row_type script[$];
   int             errors;
   bit             quiet;
   bit             settled;

   // Effective register values: zero sizes act as one and the rest is clamped.
   function automatic longint unsigned eff_w();
      return (cfg_img_w == 0) ? 1 : cfg_img_w;
   endfunction
   function automatic longint unsigned eff_h();
      return (cfg_img_h == 0) ? 1 : cfg_img_h;
   endfunction
   function automatic longint unsigned eff_tw();
      return (cfg_tile_w == 0) ? 1 : (cfg_tile_w > MAX_TILE_W ? MAX_TILE_W : cfg_tile_w);
   endfunction
   function automatic longint unsigned eff_th();
      return (cfg_tile_h == 0) ? 1 : (cfg_tile_h > MAX_TILE_H ? MAX_TILE_H : cfg_tile_h);
   endfunction
   function automatic longint unsigned eff_eb();
      return (cfg_elem == 0) ? 1 : (cfg_elem > 8 ? 8 : cfg_elem);
   endfunction
   function automatic longint unsigned eff_hx();
      return (cfg_halo_x > MAX_HALO) ? MAX_HALO : cfg_halo_x;
   endfunction
   function automatic longint unsigned eff_hy();
      return (cfg_halo_y > MAX_HALO) ? MAX_HALO : cfg_halo_y;
   endfunction
   function automatic longint unsigned eff_pitch();
      return (cfg_pitch == 0) ? eff_w() * eff_eb() : cfg_pitch;
   endfunction
   function automatic longint unsigned floor_sub(longint unsigned a, longint unsigned b);
      return (a > b) ? a - b : 0;
   endfunction

   // The halo-widened rectangle of a tile, clamped to the image.
   task automatic halo_window(input longint unsigned col, input longint unsigned row,
                              output longint unsigned fx0, output longint unsigned fy0,
                              output longint unsigned fw, output longint unsigned fh);
      longint unsigned sx, sy, x1, y1;
      sx = col * eff_tw();
      sy = row * eff_th();
      x1 = sx + eff_tw() + eff_hx();
      y1 = sy + eff_th() + eff_hy();
      if (x1 > eff_w()) x1 = eff_w();
      if (y1 > eff_h()) y1 = eff_h();
      fx0 = floor_sub(sx, eff_hx());
      fy0 = floor_sub(sy, eff_hy());
      fw = floor_sub(x1, fx0);
      fh = floor_sub(y1, fy0);
   endtask

   // The unwidened bounds of the current tile.
   task automatic tile_bounds(output longint unsigned sx, output longint unsigned sy,
                              output longint unsigned cw, output longint unsigned ch);
      longint unsigned ex, ey;
      sx = longint'(walk_col) * eff_tw();
      sy = longint'(walk_row) * eff_th();
      ex = sx + eff_tw();
      ey = sy + eff_th();
      if (ex > eff_w()) ex = eff_w();
      if (ey > eff_h()) ey = eff_h();
      cw = floor_sub(ex, sx);
      ch = floor_sub(ey, sy);
   endtask

   task automatic expect_row(input logic [1:0] kind, input logic bsel,
                             input longint unsigned mem_off, input longint unsigned buf_off,
                             input longint unsigned nbytes);
      tile_word_type w;
      w = '{default: '0};
      w.kind = kind;
      w.bsel = bsel;
      w.mem_off = mem_off[35:0];
      w.buf_off = buf_off[15:0];
      w.nbytes = nbytes[11:0];
      expected_words.push_back(w);
   endtask

   task automatic expect_status(input logic [1:0] kind);
      longint unsigned sx, sy, cw, ch;
      tile_word_type w;
      tile_bounds(sx, sy, cw, ch);
      w.kind = kind;
      w.bsel = walk_buf;
      w.mem_off = '0;
      w.buf_off = '0;
      w.nbytes = '0;
      w.tile = walk_count;
      w.scol = sx[15:0];
      w.srow = sy[15:0];
      w.cw = cw[8:0];
      w.ch = ch[4:0];
      w.fin_tile = walk_final;
      w.last_run = 1'b1;
      expected_words.push_back(w);
   endtask

   task automatic expect_prefetch(input logic [31:0] pf_tile, input logic bsel);
      longint unsigned acr, fx0, fy0, fw, fh, rb;
      acr = (walk_across == 0) ? 1 : walk_across;
      halo_window(pf_tile % acr, pf_tile / acr, fx0, fy0, fw, fh);
      rb = fw * eff_eb();
      for (longint unsigned r = 0; r < fh; r++)
         expect_row(KIND_PREFETCH, bsel, (fy0 + r) * eff_pitch() + fx0 * eff_eb(), r * rb, rb);
   endtask

   task automatic expect_writeback();
      longint unsigned sx, sy, cw, ch, fx0, fy0, fw, fh;
      tile_bounds(sx, sy, cw, ch);
      halo_window(walk_col, walk_row, fx0, fy0, fw, fh);
      for (longint unsigned r = 0; r < ch; r++)
         expect_row(KIND_WRITEBACK, walk_buf, (sy + r) * eff_pitch() + sx * eff_eb(),
                    ((floor_sub(sy, fy0) + r) * fw + floor_sub(sx, fx0)) * eff_eb(),
                    cw * eff_eb());
   endtask

   // Works out every word that one command produces and steps the shadow walker.
   task automatic predict_command(input logic [1:0] cmd, input logic dirty,
                                  input logic [31:0] req_tile);
      longint unsigned across, down;
      case (cmd)
         CMD_BEGIN: begin
            across = (eff_w() + eff_tw() - 1) / eff_tw();
            down = (eff_h() + eff_th() - 1) / eff_th();
            walk_across = across[31:0];
            walk_total = 32'(across * down);
            walk_col = '0;
            walk_row = '0;
            walk_count = '0;
            walk_buf = 1'b0;
            expect_prefetch(0, 1'b0);
            if (walk_total > 1) expect_prefetch(1, 1'b1);
            walk_final = (walk_total <= 1);
            expect_status(KIND_STATUS);
         end
         CMD_NEXT: begin
            if (walk_final) begin
               expect_status(KIND_REFUSED);
            end else begin
               if (dirty) expect_writeback();
               walk_count = walk_count + 1;
               walk_col = walk_col + 1;
               if (walk_col >= walk_across) begin
                  walk_col = '0;
                  walk_row = walk_row + 1;
               end
               walk_buf = ~walk_buf;
               if (longint'(walk_count) + 1 < walk_total)
                  expect_prefetch(walk_count + 1, ~walk_buf);
               walk_final = (longint'(walk_count) + 1 >= walk_total);
               expect_status(KIND_STATUS);
            end
         end
         CMD_END: begin
            if (dirty) expect_writeback();
            expect_status(KIND_STATUS);
         end
         default: begin
            if (req_tile >= walk_total) begin
               expect_status(KIND_REFUSED);
            end else begin
               expect_prefetch(req_tile, ~walk_buf);
               expect_status(KIND_STATUS);
            end
         end
      endcase
   endtask

   // Drops the request valid if it is still up and lets the drop take effect.
   task automatic release_request();
      if (req_chan.valid) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Waits until the walker has nothing left to say, then lets it settle.
   task automatic drain_and_settle();
      while (expected_words.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      settled = 1'b1;
   endtask

   task automatic write_register(input logic [2:0] idx, input logic [19:0] data);
      release_request();
      if (!settled) drain_and_settle();
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_IMAGE_WIDTH:   cfg_img_w = data[15:0];
         REG_IMAGE_HEIGHT:  cfg_img_h = data[15:0];
         REG_TILE_WIDTH:    cfg_tile_w = data[8:0];
         REG_TILE_HEIGHT:   cfg_tile_h = data[4:0];
         REG_ROW_PITCH:     cfg_pitch = data;
         REG_ELEMENT_BYTES: cfg_elem = data[3:0];
         REG_HALO_COLUMNS:  cfg_halo_x = data[2:0];
         default:           cfg_halo_y = data[2:0];
      endcase
   endtask

   // Presents one command word and holds it until the walker takes it.
   // When has_exp is set, the typed-in word stands in for the prediction.
   task automatic send_command(input logic [1:0] cmd, input logic dirty,
                               input logic [31:0] req_tile, input bit has_exp,
                               input tile_word_type exp_word);
      settled = 1'b0;
      req_chan.valid <= 1'b1;
      req_chan.cmd <= cmd;
      req_chan.tile_was_modified <= dirty;
      req_chan.requested_tile <= req_tile;
      do @(posedge clock); while (!req_chan.ready);
      if (has_exp) expected_words.push_back(exp_word);
      else predict_command(cmd, dirty, req_tile);
      // Sometimes the sender goes quiet for a while after a word.
      if (!quiet && $urandom_range(0, 3) == 0) begin
         release_request();
         repeat ($urandom_range(0, 15)) @(posedge clock);
      end
   endtask

   task automatic check_field(input string name, input longint unsigned exp_v,
                              input longint unsigned act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, exp_v, act_v);
         errors++;
      end
   endtask

   // The result side: every accepted word is checked against the oldest prediction,
   // and ready is dropped in random bursts while the run is not in its quiet tail.
   int stall_left;
   always @(posedge clock) begin
      tile_word_type w;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual kind %0h", $realtime,
                        rsp_chan.kind);
               errors++;
            end else begin
               w = expected_words.pop_front();
               check_field("kind", w.kind, rsp_chan.kind);
               check_field("buffer_select", w.bsel, rsp_chan.buffer_select);
               check_field("memory_offset", w.mem_off, rsp_chan.memory_offset);
               check_field("buffer_offset", w.buf_off, rsp_chan.buffer_offset);
               check_field("byte_count", w.nbytes, rsp_chan.byte_count);
               check_field("tile_number", w.tile, rsp_chan.tile_number);
               check_field("start_col", w.scol, rsp_chan.start_col);
               check_field("start_row", w.srow, rsp_chan.start_row);
               check_field("cur_width", w.cw, rsp_chan.cur_width);
               check_field("cur_height", w.ch, rsp_chan.cur_height);
               check_field("is_last_tile", w.fin_tile, rsp_chan.is_last_tile);
               check_field("last_of_run", w.last_run, rsp_chan.last_of_run);
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 15);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   task automatic add_csr(input logic [2:0] idx, input logic [19:0] data);
      script_row_type r;
      r = '{default: '0};
      r.is_csr = 1'b1;
      r.idx = idx;
      r.data = data;
      script.push_back(r);
   endtask

   task automatic add_cmd(input logic [1:0] cmd, input logic dirty, input logic [31:0] req_tile);
      script_row_type r;
      r = '{default: '0};
      r.cmd = cmd;
      r.dirty = dirty;
      r.req_tile = req_tile;
      script.push_back(r);
   endtask

   // A command whose single word is known by inspection: the reset geometry is one
   // element in one tile, so the status shows tile zero, one by one, and last.
   task automatic add_reset_cmd(input logic [1:0] cmd, input logic [31:0] req_tile,
                                input logic [1:0] kind);
      script_row_type r;
      r = '{default: '0};
      r.cmd = cmd;
      r.req_tile = req_tile;
      r.has_exp = 1'b1;
      r.exp_word = '{kind, 1'b0, 36'd0, 16'd0, 12'd0, 32'd0, 16'd0, 16'd0, 9'd1, 5'd1,
                     1'b1, 1'b1};
      script.push_back(r);
   endtask

   // A random but legal-looking register value, with the extremes mixed in.
   function automatic logic [19:0] pick_value(input logic [2:0] idx);
      int sel;
      sel = $urandom_range(0, 9);
      case (idx)
         REG_IMAGE_WIDTH:   return (sel == 0) ? 20'd0 : (sel == 1) ? 20'hFFFF :
                                   (sel == 2) ? 20'($urandom()) : 20'($urandom_range(1, 700));
         REG_IMAGE_HEIGHT:  return (sel == 0) ? 20'd0 : (sel == 1) ? 20'hFFFF :
                                   (sel == 2) ? 20'($urandom()) : 20'($urandom_range(1, 80));
         REG_TILE_WIDTH:    return (sel < 2) ? 20'($urandom_range(0, 511)) :
                                   (sel == 2) ? 20'd256 : 20'($urandom_range(1, 64));
         REG_TILE_HEIGHT:   return (sel < 2) ? 20'($urandom_range(0, 31)) :
                                   20'($urandom_range(1, 16));
         REG_ROW_PITCH:     return (sel == 0) ? 20'd0 : (sel == 1) ? 20'hFFFFF :
                                   20'($urandom());
         REG_ELEMENT_BYTES: return (sel < 2) ? 20'($urandom_range(0, 15)) :
                                   20'(1 << $urandom_range(0, 3));
         default:           return 20'($urandom_range(0, 7));
      endcase
   endfunction

   initial begin
      logic [1:0]  cmd;
      logic [31:0] req_tile;
      int          sent;
      int          phase_len;
      int          sel;

      errors = 0;
      quiet = 1'b0;
      settled = 1'b0;
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.cmd <= CMD_BEGIN;
      req_chan.tile_was_modified <= 1'b0;
      req_chan.requested_tile <= '0;
      csr_write_enable <= 1'b0;
      csr_index <= '0;
      csr_write_data <= '0;

      // The shadow walker starts where reset leaves the real one.
      cfg_img_w = 1; cfg_img_h = 1; cfg_tile_w = 1; cfg_tile_h = 1;
      cfg_pitch = 1; cfg_elem = 1; cfg_halo_x = 0; cfg_halo_y = 0;
      walk_col = '0; walk_row = '0; walk_count = '0; walk_buf = 1'b0;
      walk_final = 1'b1; walk_across = '0; walk_total = '0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Before any begin there are no tiles: next and prefetch are refused and end
      // reports tile zero, writing it back first when it is dirty.
      add_reset_cmd(CMD_NEXT, 32'd0, KIND_REFUSED);
      add_reset_cmd(CMD_PREFETCH, 32'd0, KIND_REFUSED);
      add_reset_cmd(CMD_END, 32'd0, KIND_STATUS);
      add_cmd(CMD_END, 1'b1, 32'd0);

      // A 10 x 5 image in 4 x 2 tiles with a one-element halo: nine tiles with
      // clipped edges. A zero pitch means rows are packed back to back.
      add_csr(REG_IMAGE_WIDTH, 20'd10);
      add_csr(REG_IMAGE_HEIGHT, 20'd5);
      add_csr(REG_TILE_WIDTH, 20'd4);
      add_csr(REG_TILE_HEIGHT, 20'd2);
      add_csr(REG_ROW_PITCH, 20'd0);
      add_csr(REG_ELEMENT_BYTES, 20'd2);
      add_csr(REG_HALO_COLUMNS, 20'd1);
      add_csr(REG_HALO_ROWS, 20'd1);
      add_cmd(CMD_BEGIN, 1'b1, 32'd0);
      add_cmd(CMD_NEXT, 1'b1, 32'd0);
      add_cmd(CMD_PREFETCH, 1'b0, 32'd8);
      add_cmd(CMD_PREFETCH, 1'b0, 32'd9);
      add_cmd(CMD_PREFETCH, 1'b1, 32'hFFFF_FFFF);
      add_cmd(CMD_END, 1'b1, 32'd0);
      for (int i = 0; i < 8; i++) add_cmd(CMD_NEXT, i[0], 32'd0);

      // Largest image and tiles, widest pitch, eight-byte elements and full halo.
      add_csr(REG_IMAGE_WIDTH, 20'hFFFF);
      add_csr(REG_IMAGE_HEIGHT, 20'hFFFF);
      add_csr(REG_TILE_WIDTH, 20'd256);
      add_csr(REG_TILE_HEIGHT, 20'd16);
      add_csr(REG_ROW_PITCH, 20'hFFFFF);
      add_csr(REG_ELEMENT_BYTES, 20'd8);
      add_csr(REG_HALO_COLUMNS, 20'd4);
      add_csr(REG_HALO_ROWS, 20'd4);
      add_cmd(CMD_BEGIN, 1'b0, 32'd0);
      add_cmd(CMD_NEXT, 1'b1, 32'd0);
      add_cmd(CMD_PREFETCH, 1'b0, 32'd1048575);

      // Out-of-range register values are clamped or treated as one.
      add_csr(REG_IMAGE_WIDTH, 20'd0);
      add_csr(REG_TILE_WIDTH, 20'h1FF);
      add_csr(REG_TILE_HEIGHT, 20'h1F);
      add_csr(REG_ELEMENT_BYTES, 20'hF);
      add_csr(REG_HALO_COLUMNS, 20'd7);
      add_csr(REG_HALO_ROWS, 20'd7);
      add_cmd(CMD_END, 1'b1, 32'd0);
      add_cmd(CMD_BEGIN, 1'b0, 32'd0);

      foreach (script[i]) begin
         if (script[i].is_csr) write_register(script[i].idx, script[i].data);
         else send_command(script[i].cmd, script[i].dirty, script[i].req_tile,
                           script[i].has_exp, script[i].exp_word);
      end

      // Random phases: a fresh register setting, then mostly a begin followed by a
      // walk of nexts with the other commands scattered in.
      sent = 0;
      while (sent < 140) begin
         for (int r = 0; r < 8; r++) write_register(3'(r), pick_value(3'(r)));
         phase_len = $urandom_range(8, 20);
         for (int k = 0; k < phase_len && sent < 140; k++) begin
            sel = $urandom_range(0, 19);
            if ((k == 0 && sel != 0) || sel == 1) cmd = CMD_BEGIN;
            else if (sel < 13) cmd = CMD_NEXT;
            else if (sel < 16) cmd = CMD_END;
            else cmd = CMD_PREFETCH;
            if ($urandom_range(0, 3) != 0 && walk_total != 0)
               req_tile = $urandom_range(0, walk_total - 1);
            else
               req_tile = $urandom();
            if (sent == 115) quiet = 1'b1;
            send_command(cmd, 1'($urandom_range(0, 1)), req_tile, 1'b0, '{default: '0});
            sent++;
            // Once in the run, hold off until every outstanding word has arrived.
            if (sent == 60) begin
               release_request();
               while (expected_words.size() != 0) @(posedge clock);
            end
         end
      end
      release_request();

      while (expected_words.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Watchdog far beyond the slowest legal run.
   initial begin
      #20ms;
      $display("%0t: timeout with %0d words outstanding", $realtime, expected_words.size());
      $display("Verification failed");
      $finish;
   end

endmodule
